FILE: rtl/rlss_pkg.sv
// Shared types, constants and lookup functions for the random loop scale sequencer.
`default_nettype none

package rlss_pkg;

    // Note store geometry
    localparam int LOOP_DEPTH = 16;
    localparam int HEAD_W     = $clog2(LOOP_DEPTH);
    localparam int LEN_W      = $clog2(LOOP_DEPTH + 1);

    // Field widths
    localparam int VAL_W   = 4;
    localparam int RND_W   = 16;
    localparam int ROOT_W  = 7;
    localparam int NOTE_W  = 8;
    localparam int SEL_W   = 2;
    localparam int SLEN_W  = 3;
    localparam int IDX_W   = 5;
    localparam int QUO_W   = 3;

    // Shared remainder unit divisor width
    localparam int DIV_W   = (HEAD_W + 1 > 5) ? HEAD_W + 1 : 5;
    localparam int CNT_W   = $clog2(RND_W + 1);

    // Length setting that selects write mode
    localparam logic [3:0] LEN_WRITE = 4'd8;

    // Scale codes
    localparam logic [SEL_W-1:0] SCALE_MINOR_PENTA = 2'd0;
    localparam logic [SEL_W-1:0] SCALE_DORIAN      = 2'd1;
    localparam logic [SEL_W-1:0] SCALE_LYDIAN      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAND,
        ST_HEAD,
        ST_SPRD,
        ST_DIVL
    } t_state;

    // Scale code 3 falls back to lydian
    function automatic logic [SEL_W-1:0] scale_eff(input logic [SEL_W-1:0] sel);
        scale_eff = (sel > SCALE_LYDIAN) ? SCALE_LYDIAN : sel;
    endfunction

    function automatic logic [SLEN_W-1:0] scale_len(input logic [SEL_W-1:0] sel);
        logic [SLEN_W-1:0] res;
        unique case (sel)
            SCALE_MINOR_PENTA: res = 3'd5;
            SCALE_DORIAN:      res = 3'd6;
            default:           res = 3'd7;
        endcase
        scale_len = res;
    endfunction

    // Semitone offset of scale degree within one octave
    function automatic logic [3:0] scale_base(input logic [SEL_W-1:0] sel,
                                              input logic [2:0] deg);
        logic [3:0] res;
        unique case (sel)
            SCALE_MINOR_PENTA: begin
                unique case (deg)
                    3'd0:    res = 4'd0;
                    3'd1:    res = 4'd3;
                    3'd2:    res = 4'd5;
                    3'd3:    res = 4'd7;
                    3'd4:    res = 4'd10;
                    default: res = 4'd0;
                endcase
            end
            SCALE_DORIAN: begin
                unique case (deg)
                    3'd0:    res = 4'd0;
                    3'd1:    res = 4'd2;
                    3'd2:    res = 4'd3;
                    3'd3:    res = 4'd5;
                    3'd4:    res = 4'd7;
                    3'd5:    res = 4'd10;
                    default: res = 4'd0;
                endcase
            end
            default: begin
                unique case (deg)
                    3'd0:    res = 4'd0;
                    3'd1:    res = 4'd2;
                    3'd2:    res = 4'd4;
                    3'd3:    res = 4'd6;
                    3'd4:    res = 4'd7;
                    3'd5:    res = 4'd9;
                    3'd6:    res = 4'd11;
                    default: res = 4'd0;
                endcase
            end
        endcase
        scale_base = res;
    endfunction

    // Loop length for a length setting, saturated to the store depth
    function automatic logic [LEN_W-1:0] loop_len(input logic [3:0] len_sel);
        int raw;
        unique case (len_sel)
            4'd0:    raw = 2;
            4'd1:    raw = 4;
            4'd2:    raw = 6;
            4'd3:    raw = 7;
            4'd4:    raw = 8;
            4'd5:    raw = 12;
            default: raw = 16;
        endcase
        if (raw > LOOP_DEPTH) begin
            raw = LOOP_DEPTH;
        end
        loop_len = LEN_W'(raw);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/random_loop_scale_sequencer_core.sv
// Top level: looping random note sequencer with scale quantizer on one shared remainder unit.
`default_nettype none

// One item is taken when start is high and busy is low; busy then stays high
// while a single restoring remainder/quotient unit (one dividend bit per cycle)
// runs each step in turn. Write mode (length setting 8 or more) runs the
// random mod 2L step, then head wrap, spread and octave split; play mode
// skips the random step. An item with clock trigger low only applies the
// head reset and latches its settings, without raising busy.
// The result appears for exactly one cycle with o_strobe high, in the same
// cycle that busy falls; the receiver cannot stall it, so it must sample it then.
// The scale register is written at any edge with i_cfg_we high and should
// only be changed while busy is low.
module random_loop_scale_sequencer_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [rlss_pkg::SEL_W-1:0]    i_cfg_wdata,
    input  wire                          start,
    output logic                         busy,
    input  wire                          i_clock_trigger,
    input  wire                          i_reset_trigger,
    input  wire [rlss_pkg::ROOT_W-1:0]   i_root_pitch,
    input  wire [3:0]                    i_spread_setting,
    input  wire signed [3:0]             i_shift_setting,
    input  wire [3:0]                    i_length_setting,
    input  wire [rlss_pkg::RND_W-1:0]    i_random_value,
    output logic                         o_strobe,
    output logic [rlss_pkg::NOTE_W-1:0]  o_note_semitones,
    output logic [rlss_pkg::HEAD_W-1:0]  o_read_position,
    output logic                         o_new_note_written
);
    import rlss_pkg::*;

    // State and datapath registers
    t_state              r_state, n_state;
    logic [SEL_W-1:0]    r_scale, n_scale;
    logic [DIV_W-1:0]    r_rem, n_rem;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [RND_W-1:0]    r_dvd, n_dvd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DIV_W-1:0]    r_div, n_div;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [HEAD_W-1:0]   r_wh, n_wh;
    logic [HEAD_W-1:0]   r_rh, n_rh;
    logic [VAL_W-1:0]    r_store [LOOP_DEPTH];
    logic [VAL_W-1:0]    n_store [LOOP_DEPTH];
    logic                r_write, n_write;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [3:0]          r_spread, n_spread;
    logic signed [3:0]   r_shift, n_shift;
    logic [NOTE_W-1:0]   r_note, n_note;
    logic [HEAD_W-1:0]   r_pos, n_pos;
    logic                r_new, n_new;
    logic                r_strobe, n_strobe;

    // Combinational helpers
    logic [SEL_W-1:0]    sel;
    logic [SLEN_W-1:0]   slen;
    logic [DIV_W:0]      sub_in;
    logic                sub_ge;
    logic [DIV_W-1:0]    step_rem;
    logic                last_step;
    logic [HEAD_W-1:0]   head_base;
    logic [HEAD_W-1:0]   new_head;
    logic [VAL_W-1:0]    play_val;
    logic [4:0]          sp_clamp;
    logic signed [4:0]   sh_ext;
    logic signed [4:0]   sh_lim;
    logic signed [4:0]   sh_clamp;
    logic [5:0]          idx_sum;
    logic [NOTE_W-1:0]   oct_part;

    assign sel  = scale_eff(r_scale);
    assign slen = scale_len(sel);

    // Shared restoring remainder step: shift in one dividend bit, subtract if it fits
    assign sub_in    = {r_rem, r_dvd[RND_W-1]};
    assign sub_ge    = sub_in >= {1'b0, r_div};
    assign step_rem  = sub_ge ? DIV_W'(sub_in - {1'b0, r_div}) : DIV_W'(sub_in);
    assign last_step = (r_cnt == CNT_W'(1));

    assign busy               = (r_state != ST_IDLE);
    assign o_strobe           = r_strobe;
    assign o_note_semitones   = r_note;
    assign o_read_position    = r_pos;
    assign o_new_note_written = r_new;

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_scale  <= SCALE_MINOR_PENTA;
            r_wh     <= '0;
            r_rh     <= '0;
            r_strobe <= 1'b0;
            for (int i = 0; i < LOOP_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_scale  <= n_scale;
            r_wh     <= n_wh;
            r_rh     <= n_rh;
            r_strobe <= n_strobe;
            r_store  <= n_store;
        end
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvd    <= n_dvd;
        r_cnt    <= n_cnt;
        r_div    <= n_div;
        r_val    <= n_val;
        r_write  <= n_write;
        r_len    <= n_len;
        r_root   <= n_root;
        r_spread <= n_spread;
        r_shift  <= n_shift;
        r_note   <= n_note;
        r_pos    <= n_pos;
        r_new    <= n_new;
    end

    // Sequencer: next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_scale   = i_cfg_we ? i_cfg_wdata : r_scale;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dvd     = r_dvd;
        n_cnt     = r_cnt;
        n_div     = r_div;
        n_val     = r_val;
        n_wh      = r_wh;
        n_rh      = r_rh;
        n_store   = r_store;
        n_write   = r_write;
        n_len     = r_len;
        n_root    = r_root;
        n_spread  = r_spread;
        n_shift   = r_shift;
        n_note    = r_note;
        n_pos     = r_pos;
        n_new     = r_new;
        n_strobe  = 1'b0;
        head_base = '0;
        new_head  = step_rem[HEAD_W-1:0];
        play_val  = '0;
        sp_clamp  = '0;
        sh_ext    = '0;
        sh_lim    = '0;
        sh_clamp  = '0;
        idx_sum   = '0;
        oct_part  = '0;

        // Every working state advances the shared unit by one bit
        if (r_state != ST_IDLE) begin
            n_rem = step_rem;
            n_quo = {r_quo[QUO_W-2:0], sub_ge};
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - CNT_W'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_reset_trigger) begin
                        n_wh = '0;
                        n_rh = '0;
                    end
                    // Capture and clamp the item's settings
                    n_root  = i_root_pitch;
                    n_write = (i_length_setting >= LEN_WRITE);
                    n_len   = loop_len(i_length_setting);

                    sp_clamp = (i_spread_setting == 4'd0) ? 5'd1 : {1'b0, i_spread_setting};
                    if (sp_clamp > {1'b0, slen, 1'b0}) begin
                        sp_clamp = {1'b0, slen, 1'b0};
                    end
                    n_spread = sp_clamp[3:0];

                    sh_ext = {i_shift_setting[3], i_shift_setting};
                    sh_lim = $signed({2'b00, slen});
                    sh_clamp = sh_ext;
                    if (sh_ext < -sh_lim) begin
                        sh_clamp = -sh_lim;
                    end
                    if (sh_ext > sh_lim) begin
                        sh_clamp = sh_lim;
                    end
                    n_shift = sh_clamp[3:0];

                    if (i_clock_trigger) begin
                        n_rem = '0;
                        n_quo = '0;
                        if (i_length_setting >= LEN_WRITE) begin
                            // Random sample modulo twice the scale length
                            n_dvd   = i_random_value;
                            n_div   = DIV_W'({slen, 1'b0});
                            n_cnt   = CNT_W'(RND_W);
                            n_state = ST_RAND;
                        end else begin
                            // Read head advance, wrapped by the loop length
                            head_base = i_reset_trigger ? '0 : r_rh;
                            n_dvd   = RND_W'({1'b0, head_base} + (HEAD_W + 1)'(1))
                                      << (RND_W - HEAD_W - 1);
                            n_div   = DIV_W'(loop_len(i_length_setting));
                            n_cnt   = CNT_W'(HEAD_W + 1);
                            n_state = ST_HEAD;
                        end
                    end
                end
            end

            ST_RAND: begin
                if (last_step) begin
                    n_val   = step_rem[VAL_W-1:0];
                    n_rem   = '0;
                    n_quo   = '0;
                    n_dvd   = RND_W'({1'b0, r_wh} + (HEAD_W + 1)'(1)) << (RND_W - HEAD_W - 1);
                    n_div   = DIV_W'(r_len);
                    n_cnt   = CNT_W'(HEAD_W + 1);
                    n_state = ST_HEAD;
                end
            end

            ST_HEAD: begin
                if (last_step) begin
                    if (r_write) begin
                        n_wh              = new_head;
                        n_rh              = new_head;
                        n_store[new_head] = r_val;
                        play_val          = r_val;
                    end else begin
                        n_rh     = new_head;
                        play_val = r_store[new_head];
                    end
                    // Stored value modulo the spread
                    n_rem   = '0;
                    n_quo   = '0;
                    n_dvd   = RND_W'(play_val) << (RND_W - VAL_W);
                    n_div   = DIV_W'(r_spread);
                    n_cnt   = CNT_W'(VAL_W);
                    n_state = ST_SPRD;
                end
            end

            ST_SPRD: begin
                if (last_step) begin
                    // Scale index L + (v mod spread) + shift, never negative
                    idx_sum = 6'(slen) + 6'(step_rem) + 6'({{2{r_shift[3]}}, r_shift});
                    n_rem   = '0;
                    n_quo   = '0;
                    n_dvd   = RND_W'(idx_sum[IDX_W-1:0]) << (RND_W - IDX_W);
                    n_div   = DIV_W'(slen);
                    n_cnt   = CNT_W'(IDX_W);
                    n_state = ST_DIVL;
                end
            end

            ST_DIVL: begin
                if (last_step) begin
                    // Octave times twelve plus degree offset plus root
                    oct_part = NOTE_W'(n_quo[1:0]) * NOTE_W'(12);
                    n_note   = oct_part
                               + NOTE_W'(scale_base(sel, step_rem[2:0]))
                               + NOTE_W'(r_root);
                    n_pos    = r_rh;
                    n_new    = r_write;
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
